### sv/rrba_pkg.sv
// ----------------------------------------------------------------------------
// rrba_pkg
// Shared types and constants of the rover ring block allocator.
// ----------------------------------------------------------------------------
package rrba_pkg;

   localparam int ARENA_BYTES  = 262144;
   localparam int HEADER_BYTES = 64;
   localparam int MAX_BLOCKS   = 63;
   localparam int SPLIT_MIN    = 256;

   localparam int ADDR_W = 6;
   localparam int NEXT_W = 7;
   localparam logic [NEXT_W-1:0] NO_BLOCK = 7'd127;

   // descriptor as stored in the descriptor memory
   typedef struct packed {
      logic [17:0]       start;
      logic [18:0]       size;
      logic [15:0]       owner;
      logic              owned;
      logic [NEXT_W-1:0] next;
   } desc_type;

   localparam int DESC_W = $bits(desc_type);

   typedef enum logic [1:0] {
      KIND_ALLOC = 2'd0,
      KIND_FLUSH = 2'd1,
      KIND_FRAME = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      RK_EVICT  = 2'd0,
      RK_ALLOC  = 2'd1,
      RK_REJECT = 2'd2,
      RK_FLUSH  = 2'd3
   } rkind_type;

   typedef enum logic [1:0] {
      ERR_NONE  = 2'd0,
      ERR_WIDTH = 2'd1,
      ERR_SIZE  = 2'd2,
      ERR_ROOM  = 2'd3
   } err_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CHECK, ST_REJECT, ST_ROVER, ST_HEAD, ST_EVICT, ST_MERGE,
      ST_NX, ST_FAIL, ST_FINISH, ST_WB, ST_POS, ST_DONE, ST_FLUSH,
      ST_FLUSH_END, ST_FRAME
   } state_type;

   // one result transaction
   typedef struct packed {
      logic [1:0]  result_kind;
      logic [15:0] owner_out;
      logic [17:0] block_offset;
      logic [18:0] block_bytes;
      logic [16:0] row_count;
      logic        thrash;
      logic [1:0]  error_code;
      logic        last;
   } rsp_type;

   // divider control and status
   typedef struct packed {
      logic        start;
      logic [16:0] dividend;
      logic [8:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [16:0] quotient;
   } div_rsp_type;

endpackage

### sv/rover_ring_block_allocator_unit.sv
// ----------------------------------------------------------------------------
// rover_ring_block_allocator_unit
// Circular arena allocator with a rover over a linked descriptor memory.
// ----------------------------------------------------------------------------
// One transaction at a time, and each result also waits for rsp_ready. An
// allocation computes its row count in the bit-serial row-count divider,
// rereads the head when the rover wraps and merges following blocks until
// the request fits. A flush walks every block in the list. Descriptors live
// in one 63-entry memory with a registered read; each merge step is a read
// of the following descriptor. Configuration writes re-initialize the arena
// at once.
module rover_ring_block_allocator_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [8:0]  req_row_width,
   input  logic [16:0] req_data_bytes,
   input  logic [15:0] req_owner_tag,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_result_kind,
   output logic [15:0] rsp_owner_out,
   output logic [17:0] rsp_block_offset,
   output logic [18:0] rsp_block_bytes,
   output logic [16:0] rsp_row_count,
   output logic        rsp_thrash,
   output logic [1:0]  rsp_error_code,
   output logic        rsp_last,
   input  logic        csr_we,
   input  logic [18:0] csr_wdata
);

   localparam int NB = rrba_pkg::MAX_BLOCKS;
   localparam int AW = rrba_pkg::ADDR_W;

   rrba_pkg::state_type state_ff, state_in;
   logic [18:0]   arena_ff, arena_in;
   logic [NB-1:0] valid_ff, valid_in;
   logic          e0_fresh_ff, e0_fresh_in;
   logic [6:0]    rover_ff, rover_in;
   logic [17:0]   frame_ff, frame_in;
   logic          wrapped_ff, wrapped_in;
   logic          wthis_ff, wthis_in;
   logic [8:0]    width_ff, width_in;
   logic [16:0]   size_ff, size_in;
   logic [15:0]   tag_ff, tag_in;
   logic [18:0]   total_ff, total_in;
   logic [AW-1:0] nb_ff, nb_in;
   logic [18:0]   pos_ff, pos_in;
   logic [1:0]    err_ff, err_in;
   rrba_pkg::desc_type cur_ff, cur_in;
   rrba_pkg::rsp_type  out_ff, out_in;
   logic          out_vld_ff, out_vld_in;
   logic [AW-1:0] raddr_q_ff, raddr_q_in;

   // memory port signals
   logic          we;
   logic [AW-1:0] waddr;
   rrba_pkg::desc_type wdata;
   logic          re;
   logic [AW-1:0] raddr;
   logic [rrba_pkg::DESC_W-1:0] ram_q;
   rrba_pkg::desc_type rd;

   rrba_pkg::div_req_type div_req;
   rrba_pkg::div_rsp_type div_rsp;

   logic          out_free;
   logic          free_found;
   logic [AW-1:0] free_idx;
   logic [18:0]   sz_total;
   logic [18:0]   leftover;
   logic          thr;

   rrba_ram #(
      .WIDTH(rrba_pkg::DESC_W),
      .DEPTH(rrba_pkg::MAX_BLOCKS)
   ) u_desc_ram (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .re    (re),
      .raddr (raddr),
      .rdata (ram_q)
   );

   rrba_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // entry zero reads as a whole free arena until written after init
   always_comb begin
      rd = rrba_pkg::desc_type'(ram_q);
      if (e0_fresh_ff && raddr_q_ff == '0) begin
         rd.start = '0;
         rd.size  = arena_ff;
         rd.owner = '0;
         rd.owned = 1'b0;
         rd.next  = rrba_pkg::NO_BLOCK;
      end
   end

   // lowest free descriptor
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = NB - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_idx   = AW'(i);
         end
      end
   end

   assign out_free = !out_vld_ff || rsp_ready;
   assign sz_total = ({2'b00, req_data_bytes} + 19'(rrba_pkg::HEADER_BYTES + 3)) & ~19'd3;
   assign leftover = cur_ff.size - total_ff;
   // with no rover the position is the arena end, which can be 2^18
   assign thr      = wrapped_ff && (wthis_ff || pos_ff >= {1'b0, frame_ff});

   // sequencer: next state, memory accesses and results
   always_comb begin
      state_in    = state_ff;
      arena_in    = arena_ff;
      valid_in    = valid_ff;
      e0_fresh_in = e0_fresh_ff;
      rover_in    = rover_ff;
      frame_in    = frame_ff;
      wrapped_in  = wrapped_ff;
      wthis_in    = wthis_ff;
      width_in    = width_ff;
      size_in     = size_ff;
      tag_in      = tag_ff;
      total_in    = total_ff;
      nb_in       = nb_ff;
      pos_in      = pos_ff;
      err_in      = err_ff;
      cur_in      = cur_ff;
      out_in      = out_ff;
      out_vld_in  = out_vld_ff && !rsp_ready;
      raddr_q_in  = raddr_q_ff;
      we          = 1'b0;
      waddr       = nb_ff;
      wdata       = cur_ff;
      re          = 1'b0;
      raddr       = '0;
      req_ready   = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = 17'(total_ff - 19'(rrba_pkg::HEADER_BYTES));
      div_req.divisor  = width_ff;

      unique case (state_ff)
         rrba_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               width_in = req_row_width;
               size_in  = req_data_bytes;
               tag_in   = req_owner_tag;
               total_in = sz_total;
               unique case (rrba_pkg::kind_type'(req_kind))
                  rrba_pkg::KIND_ALLOC: state_in = rrba_pkg::ST_CHECK;
                  rrba_pkg::KIND_FLUSH: begin
                     re       = 1'b1;
                     raddr    = '0;
                     state_in = rrba_pkg::ST_FLUSH;
                  end
                  rrba_pkg::KIND_FRAME: begin
                     wrapped_in = 1'b0;
                     if (rover_ff == rrba_pkg::NO_BLOCK) begin
                        frame_in = '0;
                     end else begin
                        re       = 1'b1;
                        raddr    = rover_ff[AW-1:0];
                        state_in = rrba_pkg::ST_FRAME;
                     end
                  end
                  default: state_in = rrba_pkg::ST_IDLE;
               endcase
            end
         end
         rrba_pkg::ST_FRAME: begin
            frame_in = rd.start;
            state_in = rrba_pkg::ST_IDLE;
         end
         rrba_pkg::ST_CHECK: begin
            if (width_ff > 9'd256) begin
               err_in   = rrba_pkg::ERR_WIDTH;
               state_in = rrba_pkg::ST_REJECT;
            end else if (size_ff == '0 || size_ff > 17'h10000) begin
               err_in   = rrba_pkg::ERR_SIZE;
               state_in = rrba_pkg::ST_REJECT;
            end else if (total_ff > arena_ff) begin
               err_in   = rrba_pkg::ERR_ROOM;
               state_in = rrba_pkg::ST_REJECT;
            end else if (rover_ff == rrba_pkg::NO_BLOCK) begin
               wthis_in = 1'b0;
               re       = 1'b1;
               raddr    = '0;
               state_in = rrba_pkg::ST_HEAD;
            end else begin
               re       = 1'b1;
               raddr    = rover_ff[AW-1:0];
               state_in = rrba_pkg::ST_ROVER;
            end
         end
         rrba_pkg::ST_REJECT: begin
            if (out_free) begin
               out_in     = '0;
               out_in.result_kind = rrba_pkg::RK_REJECT;
               out_in.owner_out   = tag_ff;
               out_in.error_code  = err_ff;
               out_in.last        = 1'b1;
               out_vld_in = 1'b1;
               state_in   = rrba_pkg::ST_IDLE;
            end
         end
         rrba_pkg::ST_ROVER: begin
            if ({1'b0, rd.start} > arena_ff - total_ff) begin
               wthis_in = 1'b1;
               re       = 1'b1;
               raddr    = '0;
               state_in = rrba_pkg::ST_HEAD;
            end else begin
               wthis_in = 1'b0;
               cur_in   = rd;
               nb_in    = rover_ff[AW-1:0];
               state_in = rrba_pkg::ST_EVICT;
            end
         end
         rrba_pkg::ST_HEAD: begin
            cur_in   = rd;
            nb_in    = raddr_q_ff;
            state_in = rrba_pkg::ST_EVICT;
         end
         rrba_pkg::ST_EVICT: begin
            if (!cur_ff.owned) begin
               state_in = rrba_pkg::ST_MERGE;
            end else if (out_free) begin
               out_in     = '0;
               out_in.result_kind = rrba_pkg::RK_EVICT;
               out_in.owner_out   = cur_ff.owner;
               out_vld_in = 1'b1;
               cur_in.owned = 1'b0;
               state_in   = rrba_pkg::ST_MERGE;
            end
         end
         rrba_pkg::ST_MERGE: begin
            if (cur_ff.size >= total_ff) begin
               state_in = rrba_pkg::ST_FINISH;
            end else if (cur_ff.next >= 7'(NB)) begin
               state_in = rrba_pkg::ST_FAIL;
            end else begin
               re       = 1'b1;
               raddr    = cur_ff.next[AW-1:0];
               state_in = rrba_pkg::ST_NX;
            end
         end
         rrba_pkg::ST_NX: begin
            if (!rd.owned || out_free) begin
               if (rd.owned) begin
                  out_in     = '0;
                  out_in.result_kind = rrba_pkg::RK_EVICT;
                  out_in.owner_out   = rd.owner;
                  out_vld_in = 1'b1;
               end
               cur_in.size = cur_ff.size + rd.size;
               cur_in.next = rd.next;
               valid_in[raddr_q_ff] = 1'b0;
               state_in = rrba_pkg::ST_MERGE;
            end
         end
         rrba_pkg::ST_FAIL: begin
            if (out_free) begin
               we         = 1'b1;
               rover_in   = rrba_pkg::NO_BLOCK;
               out_in     = '0;
               out_in.result_kind = rrba_pkg::RK_REJECT;
               out_in.owner_out   = tag_ff;
               out_in.error_code  = rrba_pkg::ERR_ROOM;
               out_in.last        = 1'b1;
               out_vld_in = 1'b1;
               state_in   = rrba_pkg::ST_IDLE;
            end
         end
         rrba_pkg::ST_FINISH: begin
            rover_in = cur_ff.next;
            if (leftover > 19'(rrba_pkg::SPLIT_MIN) && free_found) begin
               we          = 1'b1;
               waddr       = free_idx;
               wdata.start = cur_ff.start + total_ff[17:0];
               wdata.size  = leftover;
               wdata.owner = '0;
               wdata.owned = 1'b0;
               wdata.next  = cur_ff.next;
               valid_in[free_idx] = 1'b1;
               cur_in.next = {1'b0, free_idx};
               cur_in.size = total_ff;
               rover_in    = {1'b0, free_idx};
            end
            cur_in.owner = tag_ff;
            cur_in.owned = 1'b1;
            state_in     = rrba_pkg::ST_WB;
         end
         rrba_pkg::ST_WB: begin
            we            = 1'b1;
            div_req.start = 1'b1;
            pos_in        = arena_ff;
            if (rover_ff != rrba_pkg::NO_BLOCK) begin
               re    = 1'b1;
               raddr = rover_ff[AW-1:0];
            end
            state_in = rrba_pkg::ST_POS;
         end
         rrba_pkg::ST_POS: begin
            if (rover_ff != rrba_pkg::NO_BLOCK) begin
               pos_in = {1'b0, rd.start};
            end
            state_in = rrba_pkg::ST_DONE;
         end
         rrba_pkg::ST_DONE: begin
            if (div_rsp.done && out_free) begin
               out_in     = '0;
               out_in.result_kind  = rrba_pkg::RK_ALLOC;
               out_in.owner_out    = tag_ff;
               out_in.block_offset = cur_ff.start;
               out_in.block_bytes  = cur_ff.size;
               out_in.row_count    = div_rsp.quotient;
               out_in.thrash       = thr;
               out_in.last         = 1'b1;
               out_vld_in = 1'b1;
               if (!thr && wthis_ff) begin
                  wrapped_in = 1'b1;
               end
               state_in = rrba_pkg::ST_IDLE;
            end
         end
         rrba_pkg::ST_FLUSH: begin
            if (!rd.owned || out_free) begin
               if (rd.owned) begin
                  out_in     = '0;
                  out_in.result_kind = rrba_pkg::RK_EVICT;
                  out_in.owner_out   = rd.owner;
                  out_vld_in = 1'b1;
               end
               if (rd.next >= 7'(NB)) begin
                  state_in = rrba_pkg::ST_FLUSH_END;
               end else begin
                  re    = 1'b1;
                  raddr = rd.next[AW-1:0];
               end
            end
         end
         rrba_pkg::ST_FLUSH_END: begin
            if (out_free) begin
               out_in     = '0;
               out_in.result_kind = rrba_pkg::RK_FLUSH;
               out_in.last        = 1'b1;
               out_vld_in  = 1'b1;
               valid_in    = NB'(1);
               e0_fresh_in = 1'b1;
               rover_in    = '0;
               state_in    = rrba_pkg::ST_IDLE;
            end
         end
         default: state_in = rrba_pkg::ST_IDLE;
      endcase

      if (re) begin
         raddr_q_in = raddr;
      end
      if (we && waddr == '0) begin
         e0_fresh_in = 1'b0;
      end

      // register write: saturate and re-initialize the arena
      if (csr_we) begin
         arena_in    = (csr_wdata > 19'(rrba_pkg::ARENA_BYTES)) ?
                       19'(rrba_pkg::ARENA_BYTES) : csr_wdata;
         valid_in    = NB'(1);
         e0_fresh_in = 1'b1;
         rover_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= rrba_pkg::ST_IDLE;
         arena_ff    <= 19'(rrba_pkg::ARENA_BYTES);
         valid_ff    <= NB'(1);
         e0_fresh_ff <= 1'b1;
         rover_ff    <= '0;
         frame_ff    <= '0;
         wrapped_ff  <= 1'b0;
         out_vld_ff  <= 1'b0;
         raddr_q_ff  <= '0;
      end else begin
         state_ff    <= state_in;
         arena_ff    <= arena_in;
         valid_ff    <= valid_in;
         e0_fresh_ff <= e0_fresh_in;
         rover_ff    <= rover_in;
         frame_ff    <= frame_in;
         wrapped_ff  <= wrapped_in;
         out_vld_ff  <= out_vld_in;
         raddr_q_ff  <= raddr_q_in;
      end
      wthis_ff <= wthis_in;
      width_ff <= width_in;
      size_ff  <= size_in;
      tag_ff   <= tag_in;
      total_ff <= total_in;
      nb_ff    <= nb_in;
      pos_ff   <= pos_in;
      err_ff   <= err_in;
      cur_ff   <= cur_in;
      out_ff   <= out_in;
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_result_kind  = out_ff.result_kind;
   assign rsp_owner_out    = out_ff.owner_out;
   assign rsp_block_offset = out_ff.block_offset;
   assign rsp_block_bytes  = out_ff.block_bytes;
   assign rsp_row_count    = out_ff.row_count;
   assign rsp_thrash       = out_ff.thrash;
   assign rsp_error_code   = out_ff.error_code;
   assign rsp_last         = out_ff.last;

endmodule

### sv/rrba_ram.sv
// ----------------------------------------------------------------------------
// rrba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rrba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // read port, data holds while not enabled
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### sv/rrba_div.sv
// ----------------------------------------------------------------------------
// rrba_div
// Restoring divider, one quotient bit per cycle; divisor zero gives zero.
// ----------------------------------------------------------------------------
module rrba_div (
   input  logic                 clock,
   input  logic                 reset,
   input  rrba_pkg::div_req_type div_req,
   output rrba_pkg::div_rsp_type div_rsp
);

   logic [16:0] quo_ff, quo_in;
   logic [9:0]  rem_ff, rem_in;
   logic [8:0]  dvs_ff, dvs_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [10:0] trial;

   // one step of shift and subtract
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      trial   = {rem_ff, quo_ff[16]} - {2'b00, dvs_ff};
      if (div_req.start) begin
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dvs_in  = div_req.divisor;
         cnt_in  = 5'd17;
         busy_in = (div_req.divisor != '0);
         done_in = 1'b0;
         if (div_req.divisor == '0) begin
            quo_in  = '0;
            done_in = 1'b1;
         end
      end else if (busy_ff) begin
         if (!trial[10]) begin
            rem_in = trial[9:0];
            quo_in = {quo_ff[15:0], 1'b1};
         end else begin
            rem_in = {rem_ff[8:0], quo_ff[16]};
            quo_in = {quo_ff[15:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

### sim/rover_ring_block_allocator_unit_tb.sv
// ----------------------------------------------------------------------------
// rover_ring_block_allocator_unit_tb
// Self-checking bench for the rover ring block allocator: a queue-fed driver
// pushes allocate, flush, frame-start and no-op transactions with random gaps, a
// monitor compares every result against an in-bench allocator model, and the
// arena size register is swept between phases while the block is idle.
// ----------------------------------------------------------------------------
module rover_ring_block_allocator_unit_tb;

   typedef struct packed {
      rrba_pkg::kind_type kind;
      logic [8:0]  width;
      logic [16:0] size;
      logic [15:0] tag;
   } alloc_req_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_kind;
   logic [8:0]  req_row_width;
   logic [16:0] req_data_bytes;
   logic [15:0] req_owner_tag;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_result_kind;
   logic [15:0] rsp_owner_out;
   logic [17:0] rsp_block_offset;
   logic [18:0] rsp_block_bytes;
   logic [16:0] rsp_row_count;
   logic        rsp_thrash;
   logic [1:0]  rsp_error_code;
   logic        rsp_last;
   logic        csr_we;
   logic [18:0] csr_wdata;

   rover_ring_block_allocator_unit u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_kind(req_kind),
      .req_row_width(req_row_width), .req_data_bytes(req_data_bytes),
      .req_owner_tag(req_owner_tag),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_result_kind(rsp_result_kind), .rsp_owner_out(rsp_owner_out),
      .rsp_block_offset(rsp_block_offset), .rsp_block_bytes(rsp_block_bytes),
      .rsp_row_count(rsp_row_count), .rsp_thrash(rsp_thrash),
      .rsp_error_code(rsp_error_code), .rsp_last(rsp_last),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   // arena model state
   logic [18:0] m_arena;
   logic [17:0] m_start [rrba_pkg::MAX_BLOCKS];
   logic [18:0] m_size  [rrba_pkg::MAX_BLOCKS];
   logic [15:0] m_owner [rrba_pkg::MAX_BLOCKS];
   logic        m_owned [rrba_pkg::MAX_BLOCKS];
   logic [6:0]  m_next  [rrba_pkg::MAX_BLOCKS];
   logic        m_valid [rrba_pkg::MAX_BLOCKS];
   logic [6:0]  m_rover;
   logic [17:0] m_frame_pos;
   logic        m_wrapped;

   alloc_req_type     pending_reqs[$];
   rrba_pkg::rsp_type expected_rsps[$];
   int                errors = 0;
   int                cycle_cnt = 0;
   int                rsp_cnt = 0;
   int                alloc_cnt = 0;
   int                stall_cnt = 0;
   bit                long_stall;
   int                send_wait;
   int                recv_wait;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic void arena_init();
      for (int i = 0; i < rrba_pkg::MAX_BLOCKS; i++) begin
         m_valid[i] = 1'b0;
         m_owned[i] = 1'b0;
         m_owner[i] = '0;
         m_start[i] = '0;
         m_size[i]  = '0;
         m_next[i]  = rrba_pkg::NO_BLOCK;
      end
      m_valid[0] = 1'b1;
      m_size[0]  = m_arena;
      m_rover    = '0;
   endfunction

   function automatic void push_rsp(rrba_pkg::rkind_type k, logic [15:0] o,
                                    logic [17:0] off, logic [18:0] b,
                                    logic [16:0] r, logic t,
                                    rrba_pkg::err_type e, logic l);
      rrba_pkg::rsp_type x;
      x.result_kind = k; x.owner_out = o; x.block_offset = off;
      x.block_bytes = b; x.row_count = r; x.thrash = t;
      x.error_code = e;  x.last = l;
      expected_rsps.push_back(x);
   endfunction

   function automatic void evict_block(int idx);
      if (m_owned[idx]) begin
         push_rsp(rrba_pkg::RK_EVICT, m_owner[idx], '0, '0, '0, 1'b0,
                  rrba_pkg::ERR_NONE, 1'b0);
         m_owned[idx] = 1'b0;
      end
   endfunction

   function automatic void predict_alloc(int width, int size, logic [15:0] tag);
      int  total, r, nb, nx, f, pos, rows;
      bit  wrap_now, thr, failed;
      wrap_now = 0; thr = 0; failed = 0;
      if (width > 256) begin
         push_rsp(rrba_pkg::RK_REJECT, tag, '0, '0, '0, 1'b0, rrba_pkg::ERR_WIDTH, 1'b1);
         return;
      end
      if (size == 0 || size > 'h10000) begin
         push_rsp(rrba_pkg::RK_REJECT, tag, '0, '0, '0, 1'b0, rrba_pkg::ERR_SIZE, 1'b1);
         return;
      end
      total = (size + rrba_pkg::HEADER_BYTES + 3) & ~3;
      if (total > int'(m_arena)) begin
         push_rsp(rrba_pkg::RK_REJECT, tag, '0, '0, '0, 1'b0, rrba_pkg::ERR_ROOM, 1'b1);
         return;
      end
      r = int'(m_rover);
      if (r >= rrba_pkg::MAX_BLOCKS || int'(m_start[r]) > int'(m_arena) - total) begin
         if (r < rrba_pkg::MAX_BLOCKS) wrap_now = 1;
         r = 0;
      end
      nb = r;
      evict_block(nb);
      while (int'(m_size[nb]) < total && !failed) begin
         nx = int'(m_next[nb]);
         if (nx >= rrba_pkg::MAX_BLOCKS) begin
            failed = 1;
         end else begin
            evict_block(nx);
            m_size[nb] = m_size[nb] + m_size[nx];
            m_next[nb] = m_next[nx];
            m_valid[nx] = 1'b0;
         end
      end
      if (failed) begin
         m_rover = rrba_pkg::NO_BLOCK;
         push_rsp(rrba_pkg::RK_REJECT, tag, '0, '0, '0, 1'b0, rrba_pkg::ERR_ROOM, 1'b1);
         return;
      end
      m_rover = m_next[nb];
      if (int'(m_size[nb]) - total > rrba_pkg::SPLIT_MIN) begin
         f = rrba_pkg::MAX_BLOCKS;
         for (int i = rrba_pkg::MAX_BLOCKS - 1; i >= 0; i--)
            if (!m_valid[i]) f = i;
         if (f < rrba_pkg::MAX_BLOCKS) begin
            m_valid[f] = 1'b1;
            m_start[f] = 18'(int'(m_start[nb]) + total);
            m_size[f]  = 19'(int'(m_size[nb]) - total);
            m_next[f]  = m_next[nb];
            m_owned[f] = 1'b0;
            m_owner[f] = '0;
            m_next[nb] = 7'(f);
            m_size[nb] = 19'(total);
            m_rover    = 7'(f);
         end
      end
      m_owner[nb] = tag;
      m_owned[nb] = 1'b1;
      pos = (m_rover < rrba_pkg::MAX_BLOCKS) ? int'(m_start[m_rover]) : int'(m_arena);
      if (m_wrapped && (wrap_now || pos >= int'(m_frame_pos))) thr = 1;
      else if (wrap_now) m_wrapped = 1'b1;
      rows = (width != 0) ? (total - rrba_pkg::HEADER_BYTES) / width : 0;
      push_rsp(rrba_pkg::RK_ALLOC, tag, m_start[nb], m_size[nb], 17'(rows), thr,
               rrba_pkg::ERR_NONE, 1'b1);
   endfunction

   function automatic void predict_req(alloc_req_type q);
      int c;
      case (q.kind)
         rrba_pkg::KIND_ALLOC: predict_alloc(int'(q.width), int'(q.size), q.tag);
         rrba_pkg::KIND_FLUSH: begin
            c = 0;
            while (c < rrba_pkg::MAX_BLOCKS) begin
               evict_block(c);
               c = int'(m_next[c]);
            end
            arena_init();
            push_rsp(rrba_pkg::RK_FLUSH, '0, '0, '0, '0, 1'b0, rrba_pkg::ERR_NONE, 1'b1);
         end
         rrba_pkg::KIND_FRAME: begin
            m_frame_pos = (m_rover < rrba_pkg::MAX_BLOCKS) ? m_start[m_rover] : '0;
            m_wrapped = 1'b0;
         end
         default: ;
      endcase
   endfunction

   function automatic alloc_req_type make_req(rrba_pkg::kind_type k, int w, int s,
                                              int t);
      alloc_req_type q;
      q.kind = k; q.width = 9'(w); q.size = 17'(s); q.tag = 16'(t);
      return q;
   endfunction

   // random mostly-legal request; small sizes keep blocks numerous
   function automatic alloc_req_type rand_req();
      int p, s;
      p = $urandom_range(0, 99);
      if (p < 3)  return make_req(rrba_pkg::KIND_FLUSH, $urandom, $urandom, $urandom);
      if (p < 8)  return make_req(rrba_pkg::KIND_FRAME, $urandom, $urandom, $urandom);
      if (p < 10) return make_req(rrba_pkg::KIND_NONE, $urandom, $urandom, $urandom);
      if (p < 16) return make_req(rrba_pkg::KIND_ALLOC, $urandom_range(0, 511),
                                  $urandom_range(0, 131071), $urandom);
      s = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 65536)
                                      : $urandom_range(1, 6000);
      return make_req(rrba_pkg::KIND_ALLOC, $urandom_range(0, 256), s, $urandom);
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid      <= 1'b0;
         req_kind       <= '0;
         req_row_width  <= '0;
         req_data_bytes <= '0;
         req_owner_tag  <= '0;
         send_wait      <= 0;
      end else if (req_valid && !req_ready) begin
         // hold the offered transaction
      end else if (send_wait > 0 || pending_reqs.size() == 0) begin
         req_valid <= 1'b0;
         if (send_wait > 0) send_wait <= send_wait - 1;
      end else begin
         alloc_req_type q;
         q = pending_reqs.pop_front();
         predict_req(q);
         req_valid      <= 1'b1;
         req_kind       <= q.kind;
         req_row_width  <= q.width;
         req_data_bytes <= q.size;
         req_owner_tag  <= q.tag;
         send_wait      <= $urandom_range(0, 4);
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_wait <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rrba_pkg::rsp_type x;
            rsp_cnt <= rsp_cnt + 1;
            if (expected_rsps.size() == 0) begin
               $error("unexpected result transaction kind=%0d", rsp_result_kind);
               errors++;
            end else begin
               x = expected_rsps.pop_front();
               if (rsp_result_kind === rrba_pkg::RK_ALLOC) alloc_cnt <= alloc_cnt + 1;
               if (rsp_result_kind !== x.result_kind) begin
                  $error("result_kind exp %0d got %0d", x.result_kind, rsp_result_kind);
                  errors++;
               end
               if (rsp_owner_out !== x.owner_out) begin
                  $error("owner_out exp %0d got %0d", x.owner_out, rsp_owner_out);
                  errors++;
               end
               if (rsp_block_offset !== x.block_offset) begin
                  $error("block_offset exp %0d got %0d", x.block_offset, rsp_block_offset);
                  errors++;
               end
               if (rsp_block_bytes !== x.block_bytes) begin
                  $error("block_bytes exp %0d got %0d", x.block_bytes, rsp_block_bytes);
                  errors++;
               end
               if (rsp_row_count !== x.row_count) begin
                  $error("row_count exp %0d got %0d", x.row_count, rsp_row_count);
                  errors++;
               end
               if (rsp_thrash !== x.thrash) begin
                  $error("thrash exp %0d got %0d", x.thrash, rsp_thrash);
                  errors++;
               end
               if (rsp_error_code !== x.error_code) begin
                  $error("error_code exp %0d got %0d", x.error_code, rsp_error_code);
                  errors++;
               end
               if (rsp_last !== x.last) begin
                  $error("last exp %0d got %0d", x.last, rsp_last);
                  errors++;
               end
            end
         end
         // ready pattern: long counted stall, random waits, or always ready
         if (long_stall && stall_cnt < 300) begin
            rsp_ready <= 1'b0;
            stall_cnt <= stall_cnt + 1;
         end else if (recv_wait > 0) begin
            rsp_ready <= 1'b0;
            recv_wait <= recv_wait - 1;
         end else if (rsp_valid && rsp_ready) begin
            rsp_ready <= 1'b0;
            recv_wait <= $urandom_range(0, 4);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt > 400000) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic wait_drained();
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_arena(int v);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= 19'(v);
      @(posedge clock);
      csr_we    <= 1'b0;
      m_arena = (v > rrba_pkg::ARENA_BYTES) ? 19'(rrba_pkg::ARENA_BYTES) : 19'(v);
      arena_init();
   endtask

   task automatic run_random(int n);
      for (int i = 0; i < n; i++) pending_reqs.push_back(rand_req());
      wait_drained();
   endtask

   initial begin
      long_stall = 0;
      reset = 1'b1;
      csr_we = 1'b0; csr_wdata = '0;
      m_arena = 19'(rrba_pkg::ARENA_BYTES);
      arena_init();
      m_frame_pos = '0;
      m_wrapped = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes, every kind and the width and size rejections
      pending_reqs.push_back(make_req(rrba_pkg::KIND_ALLOC, 257, 100, 16'h1111));
      pending_reqs.push_back(make_req(rrba_pkg::KIND_ALLOC, 511, 131071, 16'hFFFF));
      pending_reqs.push_back(make_req(rrba_pkg::KIND_ALLOC, 16, 0, 16'h0001));
      pending_reqs.push_back(make_req(rrba_pkg::KIND_ALLOC, 16, 65537, 16'h0002));
      pending_reqs.push_back(make_req(rrba_pkg::KIND_ALLOC, 0, 1, 16'h0000));
      pending_reqs.push_back(make_req(rrba_pkg::KIND_ALLOC, 256, 65536, 16'hA5A5));
      pending_reqs.push_back(make_req(rrba_pkg::KIND_ALLOC, 1, 65536, 16'h5A5A));
      pending_reqs.push_back(make_req(rrba_pkg::KIND_FRAME, 0, 0, 0));
      pending_reqs.push_back(make_req(rrba_pkg::KIND_ALLOC, 3, 65536, 16'h1234));
      pending_reqs.push_back(make_req(rrba_pkg::KIND_ALLOC, 7, 65536, 16'h4321));
      pending_reqs.push_back(make_req(rrba_pkg::KIND_ALLOC, 9, 300, 16'h0BAD));
      pending_reqs.push_back(make_req(rrba_pkg::KIND_NONE, 511, 131071, 16'hFFFF));
      pending_reqs.push_back(make_req(rrba_pkg::KIND_FLUSH, 0, 0, 0));
      wait_drained();

      // smallest arena: no-room, wrap, merges and thrash
      write_arena(1024);
      pending_reqs.push_back(make_req(rrba_pkg::KIND_ALLOC, 8, 1000, 16'h0010));
      pending_reqs.push_back(make_req(rrba_pkg::KIND_ALLOC, 8, 200, 16'h0011));
      pending_reqs.push_back(make_req(rrba_pkg::KIND_ALLOC, 8, 200, 16'h0012));
      pending_reqs.push_back(make_req(rrba_pkg::KIND_FRAME, 0, 0, 0));
      pending_reqs.push_back(make_req(rrba_pkg::KIND_ALLOC, 8, 500, 16'h0013));
      pending_reqs.push_back(make_req(rrba_pkg::KIND_ALLOC, 8, 600, 16'h0014));
      pending_reqs.push_back(make_req(rrba_pkg::KIND_ALLOC, 8, 900, 16'h0015));
      pending_reqs.push_back(make_req(rrba_pkg::KIND_ALLOC, 8, 100, 16'h0016));
      wait_drained();
      run_random(20);

      // receiver stalls long while the sender fills the block
      write_arena(262143 + 200000);
      long_stall = 1;
      for (int i = 0; i < 20; i++) pending_reqs.push_back(rand_req());
      while (stall_cnt < 300) @(posedge clock);
      long_stall = 0;
      wait_drained();

      // many tiny blocks exhaust the descriptor table
      write_arena(20000);
      for (int i = 0; i < 70; i++)
         pending_reqs.push_back(make_req(rrba_pkg::KIND_ALLOC, $urandom_range(1, 256),
                                         $urandom_range(1, 150), i));
      wait_drained();
      run_random(30);

      write_arena(rrba_pkg::ARENA_BYTES);
      run_random(20);

      $display("covered %0d results, %0d grants, arena sizes 1024..262144",
               rsp_cnt, alloc_cnt);
      $display("including stalls, wraps, merges, flushes and full descriptor table");
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
